// ----- rtl/alle_pkg.sv -----
// Shared types and constants for the array linked list engine.
package alle_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] KIND_READ   = 3'd0;
  localparam logic [2:0] KIND_WRITE  = 3'd1;
  localparam logic [2:0] KIND_APPEND = 3'd2;
  localparam logic [2:0] KIND_INSERT = 3'd3;
  localparam logic [2:0] KIND_REMOVE = 3'd4;
  localparam logic [2:0] KIND_SEARCH = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef enum logic [2:0] {
    OP_READ,
    OP_WRITE,
    OP_APPEND,
    OP_INSERT,
    OP_REMOVE,
    OP_SEARCH,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  pos;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_VAL_RD,
    S_VAL_GOT,
    S_TAKE,
    S_TAKE_GOT,
    S_APP_LINK,
    S_INS_RD,
    S_INS_GOT,
    S_INS_SET,
    S_REM_PREV,
    S_REM_PGOT,
    S_REM_RD,
    S_REM_GOT,
    S_REM_FREE,
    S_SRCH,
    S_DONE
  } state_t;

endpackage

// ----- rtl/alle_front.sv -----
// Front end: accepts commands and decodes the kind into an operation.
module alle_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          kind,
  input  logic [5:0]          position,
  input  logic signed [31:0]  item_value,
  input  alle_pkg::back_stat_t bstat,
  input  logic                q_full,
  output logic                q_push,
  output alle_pkg::cmd_t      q_cmd
);
  import alle_pkg::*;

  op_t op;

  always_comb begin
    unique case (kind)
      KIND_READ:   op = OP_READ;
      KIND_WRITE:  op = OP_WRITE;
      KIND_APPEND: op = OP_APPEND;
      KIND_INSERT: op = OP_INSERT;
      KIND_REMOVE: op = OP_REMOVE;
      KIND_SEARCH: op = OP_SEARCH;
      default:     op = OP_NONE;
    endcase
  end

  assign in_stall    = q_full || bstat.init_busy;
  assign q_push      = in_valid && !in_stall;
  assign q_cmd.op    = op;
  assign q_cmd.pos   = position;
  assign q_cmd.value = $unsigned(item_value);

endmodule

// ----- rtl/alle_queue.sv -----
// Short command queue between the front end and the back end.
module alle_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  alle_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output alle_pkg::cmd_t head_cmd
);
  import alle_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      fill;
  logic             do_push;
  logic             do_pop;

  assign full     = fill == (PW+1)'(QUEUE_DEPTH);
  assign nonempty = fill != '0;
  assign head_cmd = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- rtl/alle_back.sv -----
// Back end: node store, free chain and the sequencer that carries out commands.
module alle_back #(
  parameter int NODE_COUNT = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_nonempty,
  input  alle_pkg::cmd_t       q_cmd,
  output logic                 q_pop,
  output alle_pkg::back_stat_t bstat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic signed [31:0]   result_value,
  output logic [5:0]           found_position,
  output logic [6:0]           list_length
);
  import alle_pkg::*;

  localparam int IW   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int LW   = $clog2(NODE_COUNT + 1);
  localparam int CMPW = (LW > 6) ? LW : 6;
  localparam logic [LW-1:0] NONE = LW'(NODE_COUNT);

  logic [VALUE_BITS-1:0] value_mem [NODE_COUNT];
  logic [LW-1:0]         link_mem  [NODE_COUNT];

  logic [IW-1:0]         link_ra, link_wa, value_ra, value_wa;
  logic [LW-1:0]         link_wd, link_rd;
  logic [VALUE_BITS-1:0] value_wd, value_rd;
  logic                  link_we, value_we;

  state_t                state, state_next, ret, ret_next;
  cmd_t                  cmd, cmd_next;
  logic [LW-1:0]         cur, cur_next, fnode, fnode_next, vnode, vnode_next;
  logic [LW-1:0]         walk_left, walk_left_next, idx, idx_next;
  logic                  from_mem, from_mem_next;
  logic [LW-1:0]         head, head_next, free_head, free_head_next;
  logic [LW-1:0]         count, count_next;
  logic [IW-1:0]         init_idx, init_idx_next;
  logic [1:0]            res_status, res_status_next;
  logic [VALUE_BITS-1:0] res_rv, res_rv_next;
  logic [LW-1:0]         res_fpos, res_fpos_next;
  logic                  out_valid_next;
  logic [1:0]            status_next;
  logic [VALUE_BITS-1:0] out_rv, out_rv_next;
  logic [5:0]            found_position_next;
  logic [6:0]            list_length_next;

  logic                  in_range, full;
  logic [LW-1:0]         walk_node;
  logic [VALUE_BITS-1:0] cmd_v;

  assign bstat.init_busy = state == S_INIT;
  assign result_value    = 32'(out_rv);
  assign full            = count >= NONE || free_head == NONE;
  assign in_range        = CMPW'(q_cmd.pos) < CMPW'(count);
  assign cmd_v           = VALUE_BITS'(cmd.value);
  assign walk_node       = from_mem ? link_rd : cur;

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[value_wa] <= value_wd;
    end
    value_rd <= value_mem[value_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_idx  <= '0;
      head      <= NONE;
      free_head <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      init_idx  <= init_idx_next;
      head      <= head_next;
      free_head <= free_head_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ret            <= ret_next;
    cmd            <= cmd_next;
    cur            <= cur_next;
    fnode          <= fnode_next;
    vnode          <= vnode_next;
    walk_left      <= walk_left_next;
    idx            <= idx_next;
    from_mem       <= from_mem_next;
    res_status     <= res_status_next;
    res_rv         <= res_rv_next;
    res_fpos       <= res_fpos_next;
    status         <= status_next;
    out_rv         <= out_rv_next;
    found_position <= found_position_next;
    list_length    <= list_length_next;
  end

  always_comb begin
    state_next          = state;
    ret_next            = ret;
    cmd_next            = cmd;
    cur_next            = cur;
    fnode_next          = fnode;
    vnode_next          = vnode;
    walk_left_next      = walk_left;
    idx_next            = idx;
    from_mem_next       = from_mem;
    head_next           = head;
    free_head_next      = free_head;
    count_next          = count;
    init_idx_next       = init_idx;
    res_status_next     = res_status;
    res_rv_next         = res_rv;
    res_fpos_next       = res_fpos;
    status_next         = status;
    out_rv_next         = out_rv;
    found_position_next = found_position;
    list_length_next    = list_length;
    out_valid_next      = out_valid && out_stall;
    q_pop               = 1'b0;
    link_ra             = '0;
    value_ra            = '0;
    link_we             = 1'b0;
    link_wa             = '0;
    link_wd             = '0;
    value_we            = 1'b0;
    value_wa            = '0;
    value_wd            = '0;

    unique case (state)
      S_INIT: begin
        link_we = 1'b1;
        link_wa = init_idx;
        if (init_idx == IW'(NODE_COUNT - 1)) begin
          link_wd    = NONE;
          state_next = S_IDLE;
        end else begin
          link_wd       = LW'(init_idx) + 1'b1;
          init_idx_next = init_idx + 1'b1;
        end
      end
      S_IDLE: begin
        if (q_nonempty) begin
          q_pop           = 1'b1;
          cmd_next        = q_cmd;
          res_status_next = ST_OK;
          res_rv_next     = '0;
          res_fpos_next   = '0;
          cur_next        = head;
          from_mem_next   = 1'b0;
          state_next      = S_DONE;
          unique case (q_cmd.op)
            OP_READ, OP_WRITE: begin
              if (!in_range) begin
                res_status_next = ST_RANGE;
              end else begin
                walk_left_next = LW'(q_cmd.pos);
                ret_next       = S_VAL_RD;
                state_next     = S_WALK;
              end
            end
            OP_APPEND: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                state_next = S_TAKE;
              end
            end
            OP_INSERT: begin
              if (!in_range) begin
                res_status_next = ST_RANGE;
              end else if (full) begin
                res_status_next = ST_FULL;
              end else begin
                state_next = S_TAKE;
              end
            end
            OP_REMOVE: begin
              if (!in_range) begin
                res_status_next = ST_RANGE;
              end else if (q_cmd.pos == '0) begin
                vnode_next = head;
                state_next = S_REM_RD;
              end else begin
                walk_left_next = LW'(q_cmd.pos) - 1'b1;
                ret_next       = S_REM_PREV;
                state_next     = S_WALK;
              end
            end
            OP_SEARCH: begin
              if (count == '0) begin
                res_status_next = ST_MISS;
              end else begin
                link_ra    = IW'(head);
                value_ra   = IW'(head);
                idx_next   = '0;
                state_next = S_SRCH;
              end
            end
            default: begin
              res_status_next = ST_OK;
            end
          endcase
        end
      end
      S_WALK: begin
        cur_next = walk_node;
        if (walk_left == '0) begin
          state_next = ret;
        end else begin
          link_ra        = IW'(walk_node);
          from_mem_next  = 1'b1;
          walk_left_next = walk_left - 1'b1;
        end
      end
      S_VAL_RD: begin
        value_ra   = IW'(cur);
        state_next = S_VAL_GOT;
      end
      S_VAL_GOT: begin
        res_rv_next = value_rd;
        if (cmd.op == OP_WRITE) begin
          value_we = 1'b1;
          value_wa = IW'(cur);
          value_wd = cmd_v;
        end
        state_next = S_DONE;
      end
      S_TAKE: begin
        link_ra    = IW'(free_head);
        state_next = S_TAKE_GOT;
      end
      S_TAKE_GOT: begin
        fnode_next     = free_head;
        free_head_next = link_rd;
        count_next     = count + 1'b1;
        value_we       = 1'b1;
        value_wa       = IW'(free_head);
        value_wd       = cmd_v;
        link_we        = 1'b1;
        link_wa        = IW'(free_head);
        link_wd        = NONE;
        cur_next       = head;
        from_mem_next  = 1'b0;
        state_next     = S_DONE;
        if (cmd.op == OP_APPEND) begin
          if (count == '0) begin
            head_next = free_head;
          end else begin
            walk_left_next = count - 1'b1;
            ret_next       = S_APP_LINK;
            state_next     = S_WALK;
          end
        end else if (cmd.pos == '0) begin
          link_wd   = head;
          head_next = free_head;
        end else begin
          walk_left_next = LW'(cmd.pos) - 1'b1;
          ret_next       = S_INS_RD;
          state_next     = S_WALK;
        end
      end
      S_APP_LINK: begin
        link_we    = 1'b1;
        link_wa    = IW'(cur);
        link_wd    = fnode;
        state_next = S_DONE;
      end
      S_INS_RD: begin
        link_ra    = IW'(cur);
        state_next = S_INS_GOT;
      end
      S_INS_GOT: begin
        link_we    = 1'b1;
        link_wa    = IW'(fnode);
        link_wd    = link_rd;
        state_next = S_INS_SET;
      end
      S_INS_SET: begin
        link_we    = 1'b1;
        link_wa    = IW'(cur);
        link_wd    = fnode;
        state_next = S_DONE;
      end
      S_REM_PREV: begin
        link_ra    = IW'(cur);
        state_next = S_REM_PGOT;
      end
      S_REM_PGOT: begin
        vnode_next = link_rd;
        state_next = S_REM_RD;
      end
      S_REM_RD: begin
        link_ra    = IW'(vnode);
        value_ra   = IW'(vnode);
        state_next = S_REM_GOT;
      end
      S_REM_GOT: begin
        res_rv_next = value_rd;
        if (cmd.pos == '0) begin
          head_next = link_rd;
        end else begin
          link_we = 1'b1;
          link_wa = IW'(cur);
          link_wd = link_rd;
        end
        state_next = S_REM_FREE;
      end
      S_REM_FREE: begin
        link_we        = 1'b1;
        link_wa        = IW'(vnode);
        link_wd        = free_head;
        free_head_next = vnode;
        count_next     = count - 1'b1;
        state_next     = S_DONE;
      end
      S_SRCH: begin
        if (value_rd == cmd_v) begin
          res_fpos_next = idx;
          state_next    = S_DONE;
        end else if (idx + 1'b1 >= count) begin
          res_status_next = ST_MISS;
          state_next      = S_DONE;
        end else begin
          link_ra  = IW'(link_rd);
          value_ra = IW'(link_rd);
          idx_next = idx + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next      = 1'b1;
          status_next         = res_status;
          out_rv_next         = res_rv;
          found_position_next = 6'(res_fpos);
          list_length_next    = 7'(count);
          state_next          = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/array_linked_list_engine.sv -----
// Top level of the array linked list engine: front end, command queue and back end.
//
//   Channel  Handshake           Payload
//   command  in_valid/in_stall   kind, position, item_value
//   result   out_valid/out_stall status, result_value, found_position, list_length
//
// A command follows the list one link at a time, since the link store gives one
// read per cycle; the longest command is a remove at the last position.
// After reset the link store is initialized as the free chain, and in_stall is
// high during that time.
// Reset is synchronous and active high. The two-entry queue lets commands
// enter while the back end works or while a result waits under out_stall.
module array_linked_list_engine #(
  parameter int NODE_COUNT = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         kind,
  input  logic [5:0]         position,
  input  logic signed [31:0] item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] result_value,
  output logic [5:0]         found_position,
  output logic [6:0]         list_length
);
  import alle_pkg::*;

  back_stat_t bstat;
  cmd_t       push_cmd;
  cmd_t       head_cmd;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_nonempty;

  alle_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .position   (position),
    .item_value (item_value),
    .bstat      (bstat),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  alle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head_cmd (head_cmd)
  );

  alle_back #(
    .NODE_COUNT (NODE_COUNT),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_nonempty     (q_nonempty),
    .q_cmd          (head_cmd),
    .q_pop          (q_pop),
    .bstat          (bstat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .result_value   (result_value),
    .found_position (found_position),
    .list_length    (list_length)
  );

endmodule

// ----- rtl/alle_checker.sv -----
// Port-level assertions for the array linked list engine and their bind.
module alle_checker #(
  parameter int NODE_COUNT = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [31:0] result_value,
  input logic [5:0]  found_position,
  input logic [6:0]  list_length
);
  import alle_pkg::*;

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Result valid dropped while stalled.");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(result_value) && $stable(list_length))
    else $error("Result payload changed while stalled.");

  a_full_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> list_length == 7'(NODE_COUNT))
    else $error("Store full reported with a list that is not full.");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> result_value == '0 && found_position == '0)
    else $error("Failed transaction carries a nonzero value or position.");

endmodule

bind array_linked_list_engine alle_checker #(.NODE_COUNT(NODE_COUNT)) u_alle_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .result_value   (result_value),
  .found_position (found_position),
  .list_length    (list_length)
);

// ----- tb/tb_array_linked_list_engine.sv -----
// Self-checking testbench for the array linked list engine: commands in, results checked in order.
module tb_array_linked_list_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import alle_pkg::*;

  localparam int NODES = 64;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
    logic [5:0]  fpos;
    logic [6:0]  length;
  } list_result_t;

  class list_scoreboard;
    logic [31:0]  vals[NODES];
    int           links[NODES];
    int           head;
    int           free_head;
    int           count;
    list_result_t pending[$];
    int           mismatches;
    int           results_seen;

    function new();
      for (int i = 0; i < NODES; i++) begin
        vals[i] = '0;
        links[i] = i + 1;
      end
      head = NODES;
      free_head = 0;
      count = 0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function int node_at(int p);
      int cur;
      cur = head;
      for (int i = 0; i < p && cur != NODES; i++) cur = links[cur];
      return cur;
    endfunction

    function int take_free(logic [31:0] v);
      int f;
      f = free_head;
      free_head = links[f];
      vals[f] = v;
      links[f] = NODES;
      return f;
    endfunction

    function void note_command(logic [2:0] k, logic [5:0] p, logic [31:0] v);
      list_result_t r;
      bit in_range;
      bit full;
      int n;
      int f;
      int prev;
      int victim;
      r.status = ST_OK;
      r.value = '0;
      r.fpos = '0;
      in_range = p < count;
      full = count >= NODES || free_head == NODES;
      case (k)
        KIND_READ, KIND_WRITE: begin
          if (!in_range) r.status = ST_RANGE;
          else begin
            n = node_at(p);
            r.value = vals[n];
            if (k == KIND_WRITE) vals[n] = v;
          end
        end
        KIND_APPEND: begin
          if (full) r.status = ST_FULL;
          else begin
            prev = (count == 0) ? NODES : node_at(count - 1);
            f = take_free(v);
            if (prev == NODES) head = f;
            else links[prev] = f;
            count++;
          end
        end
        KIND_INSERT: begin
          if (!in_range) r.status = ST_RANGE;
          else if (full) r.status = ST_FULL;
          else begin
            prev = (p == 0) ? NODES : node_at(p - 1);
            f = take_free(v);
            if (prev == NODES) begin
              links[f] = head;
              head = f;
            end else begin
              links[f] = links[prev];
              links[prev] = f;
            end
            count++;
          end
        end
        KIND_REMOVE: begin
          if (!in_range) r.status = ST_RANGE;
          else begin
            if (p == 0) begin
              victim = head;
              head = links[victim];
            end else begin
              prev = node_at(p - 1);
              victim = links[prev];
              links[prev] = links[victim];
            end
            r.value = vals[victim];
            links[victim] = free_head;
            free_head = victim;
            count--;
          end
        end
        KIND_SEARCH: begin
          n = head;
          r.status = ST_MISS;
          for (int i = 0; i < count && n != NODES; i++) begin
            if (vals[n] == v) begin
              r.status = ST_OK;
              r.fpos = 6'(i);
              break;
            end
            n = links[n];
          end
        end
        default: ;
      endcase
      r.length = 7'(count);
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] s, logic [31:0] v, logic [5:0] fp, logic [6:0] len);
      list_result_t e;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: status %0d", s);
        return;
      end
      e = pending.pop_front();
      if (e.status !== s || e.value !== v || e.fpos !== fp || e.length !== len) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected st %0d val %h pos %0d len %0d, got st %0d val %h pos %0d len %0d",
                   e.status, e.value, e.fpos, e.length, s, v, fp, len);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  kind;
  logic [5:0]  position;
  logic [31:0] item_value;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [31:0] result_value;
  logic [5:0]  found_position;
  logic [6:0]  list_length;

  list_scoreboard sb;
  int cycles;
  int send_idle_pct;
  int stall_pct;
  int sent;

  array_linked_list_engine u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .position(position), .item_value(item_value), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .result_value(result_value),
    .found_position(found_position), .list_length(list_length)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, result_value, found_position, list_length);
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("tb_array_linked_list_engine NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_command(logic [2:0] k, logic [5:0] p, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    kind <= k;
    position <= p;
    item_value <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(k, p, v);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_command();
    logic [2:0] k;
    logic [5:0] p;
    int r;
    int len;
    len = sb.count;
    r = $urandom_range(99);
    if (r < 5) k = 3'(6 + $urandom_range(1));
    else if (r < 30) k = (len < 40) ? KIND_APPEND : KIND_REMOVE;
    else k = 3'($urandom_range(5));
    if ($urandom_range(9) == 0 || len == 0) p = 6'($urandom);
    else p = 6'($urandom_range(len - 1));
    send_command(k, p, (k == KIND_SEARCH && $urandom_range(1)) ? $urandom_range(7) : pick_value());
  endtask

  initial begin
    sb = new();
    cycles = 0;
    sent = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    kind = '0;
    position = '0;
    item_value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_command(KIND_READ, 6'd0, 32'd0);
    send_command(KIND_REMOVE, 6'd0, 32'd0);
    send_command(KIND_INSERT, 6'd0, 32'd5);
    send_command(KIND_SEARCH, 6'd0, 32'd1);
    send_command(KIND_APPEND, 6'd63, 32'h8000_0000);
    send_command(KIND_APPEND, 6'd0, 32'h7fff_ffff);
    send_command(KIND_INSERT, 6'd0, 32'hffff_ffff);
    send_command(KIND_WRITE, 6'd2, 32'h1234_5678);
    send_command(KIND_READ, 6'd2, 32'd0);
    send_command(KIND_SEARCH, 6'd0, 32'h7fff_ffff);
    send_command(KIND_REMOVE, 6'd0, 32'd0);
    send_command(KIND_INSERT, 6'd1, 32'd9);
    send_command(3'd6, 6'd63, 32'hffff_ffff);
    send_command(3'd7, 6'd0, 32'd0);
    send_command(KIND_REMOVE, 6'd1, 32'd0);
    send_command(KIND_READ, 6'd63, 32'd0);
    for (int i = 0; i < 66; i++) send_command(KIND_APPEND, 6'($urandom), $urandom);
    send_command(KIND_INSERT, 6'd10, 32'd1);
    send_command(KIND_INSERT, 6'd63, 32'd1);
    send_command(KIND_SEARCH, 6'd0, 32'h1234_5678);
    send_command(KIND_READ, 6'd63, 32'd0);
    send_command(KIND_REMOVE, 6'd63, 32'd0);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 7 : 82) : 0;
      stall_pct = (ph == 2) ? 82 : ((ph == 3) ? 7 : 0);
      for (int i = 0; i < 130; i++) random_command();
    end

    in_valid <= 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Ran %0d commands with %0d results over %0d cycles, list filled to capacity,",
             sent, sb.results_seen, cycles);
    $display("under mixed sender gaps and receiver stalls; mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_array_linked_list_engine OK");
    end else begin
      $display("tb_array_linked_list_engine NOT OK");
    end
    $finish;
  end
endmodule
